### sv/deq_pkg.sv
// Shared types, codes and ring pointer helpers for the double-ended queue.
// Used by double_ended_queue; depends on nothing else.
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic ptr_t ptr_prev(input ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

endpackage

### sv/double_ended_queue.sv
// Top level of the bounded double-ended queue: command sequencer, pointers and count.
// Depends on deq_pkg and on deq_ram for the word store.
//
// Channel   Ports                                   Transaction
// command   start, busy, in_command, in_value       start high while busy low
// result    out_valid, out_word, out_status,        one cycle per out_valid pulse
//           out_occupancy, out_last_of_run
//
// A push, an unused command, or a pop or list of an empty queue gives its result
// in the cycle after acceptance and the block can take a new command at once. A pop
// reads the RAM and returns its result via the RAM read and output registers. A list
// of N words gives one word per cycle at the RAM read port's pace, and the block is busy.
// Reset clears the pointers and the count; the store needs no clearing.
// The receiver cannot stall; every result is shown for exactly one cycle.
module double_ended_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [deq_pkg::CMD_W-1:0]           in_command,
  input  logic signed [deq_pkg::WORD_W-1:0]   in_value,
  output logic                                out_valid,
  output logic signed [deq_pkg::WORD_W-1:0]   out_word,
  output logic [deq_pkg::STAT_W-1:0]          out_status,
  output logic [deq_pkg::OCC_W-1:0]           out_occupancy,
  output logic                                out_last_of_run
);

  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIST,
    S_DRAIN
  } state_t;

  state_t              state_r, state_nxt;
  ptr_t                front_r, front_nxt;
  ptr_t                back_r, back_nxt;
  cnt_t                count_r, count_nxt;
  ptr_t                idx_r, idx_nxt;
  cnt_t                rem_r, rem_nxt;
  logic                pend_r, pend_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [OCC_W-1:0]    out_occ_r, out_occ_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_we;
  ptr_t                ram_waddr;
  ptr_t                ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic                emit;
  status_t             emit_status;
  logic                full;
  logic                empty;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    pend_nxt       = 1'b0;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = back_r;
    ram_raddr      = idx_r;
    emit           = 1'b0;
    emit_status    = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_command))
            CMD_PUSH_BACK: begin
              emit = 1'b1;
              if (full) begin
                emit_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = back_r;
                back_nxt  = ptr_next(back_r);
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_PUSH_FRONT: begin
              emit = 1'b1;
              if (full) begin
                emit_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ptr_prev(front_r);
                front_nxt = ptr_prev(front_r);
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                ram_raddr     = front_r;
                front_nxt     = ptr_next(front_r);
                count_nxt     = count_r - 1'b1;
                pend_nxt      = 1'b1;
                pend_last_nxt = 1'b1;
                state_nxt     = S_DRAIN;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                ram_raddr     = ptr_prev(back_r);
                back_nxt      = ptr_prev(back_r);
                count_nxt     = count_r - 1'b1;
                pend_nxt      = 1'b1;
                pend_last_nxt = 1'b1;
                state_nxt     = S_DRAIN;
              end
            end
            CMD_LIST: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                idx_nxt   = front_r;
                rem_nxt   = count_r;
                state_nxt = S_LIST;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_LIST: begin
        ram_raddr     = idx_r;
        pend_nxt      = 1'b1;
        pend_last_nxt = (rem_r == CNT_W'(1));
        idx_nxt       = ptr_next(idx_r);
        rem_nxt       = rem_r - 1'b1;
        if (rem_r == CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (pend_r) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = ram_rdata;
      out_status_nxt = ST_OK;
      out_occ_nxt    = OCC_W'(count_r);
      out_last_nxt   = pend_last_r;
    end else if (emit) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = '0;
      out_status_nxt = emit_status;
      out_occ_nxt    = OCC_W'(count_nxt);
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    pend_last_r  <= pend_last_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_status      = out_status_r;
  assign out_occupancy   = out_occ_r;
  assign out_last_of_run = out_last_r;

  logic [PTR_W:0] ring_sum;
  logic           ring_ok;

  assign ring_sum = {1'b0, front_r} + (PTR_W + 1)'(count_r);
  assign ring_ok  = (ring_sum == {1'b0, back_r}) ||
                    (ring_sum == ({1'b0, back_r} + (PTR_W + 1)'(DEPTH)));

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("item count exceeds the ring depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ring_ok)
    else $error("front pointer plus count does not reach the back pointer");

  a_no_pending_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !pend_r)
    else $error("RAM read pending while the sequencer is idle");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !full &&
     (in_command == CMD_PUSH_BACK || in_command == CMD_PUSH_FRONT))
    |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted push did not increase the count");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (rem_r != '0) && !empty)
    else $error("list sequence running with nothing left to read");
`endif

endmodule

### sv/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the queue's words; depends on nothing else.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
